// ===== design/gep_pkg.sv =====
// ----------------------------------------------------------------------------
// gep_pkg: shared types and constants of the graph edge table
// Payload structs, operation/status/constraint codes and sizes used by the
// front, the queue and the back of the edge table.
// ----------------------------------------------------------------------------
`default_nettype none
package gep_pkg;

	// sizes
	localparam int MAX_NODES   = 64;
	localparam int NODE_W      = 6;
	localparam int CFG_W       = 7;
	localparam int EDGE_SLOTS  = MAX_NODES * (MAX_NODES + 1) / 2;
	localparam int IX_W        = 12;
	localparam int VALUE_W     = 32;
	localparam int DEG_W       = 6;
	localparam int SUM_W       = 48;
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W     = 1;
	localparam int Q_CNT_W     = 2;

	localparam logic [CFG_W-1:0] NODES_RESET = CFG_W'(64);

	// operation codes
	localparam logic [3:0] K_INSERT  = 4'd0;
	localparam logic [3:0] K_REMOVE  = 4'd1;
	localparam logic [3:0] K_SET_COST = 4'd2;
	localparam logic [3:0] K_GET_COST = 4'd3;
	localparam logic [3:0] K_SET_CON = 4'd4;
	localparam logic [3:0] K_GET_CON = 4'd5;
	localparam logic [3:0] K_SET_DEL = 4'd6;
	localparam logic [3:0] K_GET_DEL = 4'd7;
	localparam logic [3:0] K_ADJ     = 4'd8;

	// constraint codes
	localparam logic [1:0] CON_FREE      = 2'd0;
	localparam logic [1:0] CON_FORCED    = 2'd1;
	localparam logic [1:0] CON_FORBIDDEN = 2'd2;
	localparam logic [1:0] CON_RSVD      = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_NODE = 2'd1;
	localparam logic [1:0] STAT_DUP      = 2'd2;
	localparam logic [1:0] STAT_ABSENT   = 2'd3;

	typedef struct packed {
		logic [3:0]                kind;
		logic [NODE_W-1:0]         node_a;
		logic [NODE_W-1:0]         node_b;
		logic signed [VALUE_W-1:0] edge_cost_value;
		logic signed [VALUE_W-1:0] edge_delta_value;
		logic [1:0]                constraint_code;
	} in_t;

	typedef struct packed {
		logic [1:0]                status;
		logic                      adjacent;
		logic signed [VALUE_W-1:0] read_value;
		logic [1:0]                read_constraint;
		logic [DEG_W-1:0]          degree_a;
		logic [DEG_W-1:0]          forced_degree_a;
		logic [DEG_W-1:0]          forbidden_degree_a;
		logic [DEG_W-1:0]          degree_b;
		logic [DEG_W-1:0]          forced_degree_b;
		logic [DEG_W-1:0]          forbidden_degree_b;
		logic signed [SUM_W-1:0]   total_cost;
	} out_t;

	// classified operation as it waits in the queue
	typedef struct packed {
		logic [3:0]                kind;
		logic                      ok;
		logic [NODE_W-1:0]         a;
		logic [NODE_W-1:0]         b;
		logic [IX_W-1:0]           ix;
		logic signed [VALUE_W-1:0] cost;
		logic signed [VALUE_W-1:0] delta;
		logic [1:0]                con;
	} q_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage
`default_nettype wire

// ===== design/graph_edge_table_with_degree_counts.sv =====
// ----------------------------------------------------------------------------
// graph_edge_table_with_degree_counts: undirected graph edge store
// Lower-triangular edge table with per-node degree counters and cost total.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready/in_data carry one operation per transfer (insert,
//    remove, set/get cost, set/get constraint, set/get delta, adjacency).
//  - out_valid/out_ready/out_data return exactly one result per operation,
//    in order: status, present flag, read data, both endpoints' counters
//    and the running cost total.
//  - cfg_we/cfg_wdata write the number of nodes in use; write only while
//    no operation is outstanding.
//  - After reset the block sweeps the edge and counter memories, one entry
//    a cycle: in_ready stays low until the sweep is done.
//  - Each operation runs through the back-end steps fetch, update edge and
//    node a, and write node b, an order set by the single write port of the
//    counter memory; out_valid rises once the node b write step loads the
//    output register, and the result transfer can follow on the next edge.
//  - A two-entry queue keeps the input side open while the back end works;
//    when the receiver stalls, the result waits in the output register and
//    the back end stops once it has the next result ready.
// ----------------------------------------------------------------------------
`default_nettype none
module graph_edge_table_with_degree_counts (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire gep_pkg::in_t      in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output gep_pkg::out_t          out_data,
	input  wire logic              cfg_we,
	input  wire logic [6:0]        cfg_wdata
);
	import gep_pkg::*;

	logic     push, pop, init_done;
	q_item_t  push_item, head;
	q_stat_t  q_stat;

	gep_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.init_done (init_done),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	gep_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	gep_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_head    (head),
		.q_pop     (pop),
		.init_done (init_done),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== design/gep_front.sv =====
// ----------------------------------------------------------------------------
// gep_front: operation intake and classification
// Holds the node count register, checks the endpoints, folds unknown codes,
// computes the triangular edge index and pushes the operation to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module gep_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire gep_pkg::in_t          in_data,
	input  wire logic                  cfg_we,
	input  wire logic [6:0]            cfg_wdata,
	input  wire logic                  init_done,
	input  wire gep_pkg::q_stat_t      q_stat,
	output logic                       push,
	output gep_pkg::q_item_t           push_item
);
	import gep_pkg::*;

	logic [CFG_W-1:0]  nodes_in_use_q;
	logic [NODE_W-1:0] hi, lo;
	logic [NODE_W:0]   hi_p1;
	logic [IX_W:0]     tri_prod;
	logic              a_ok, b_ok;

	// node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_in_use_q <= NODES_RESET;
		end else if (cfg_we) begin
			nodes_in_use_q <= cfg_wdata;
		end
	end

	// intake handshake: no transfer while the store is being cleared
	assign in_ready = init_done && !q_stat.full;
	assign push     = in_valid && in_ready;

	// endpoint checks and edge index hi*(hi+1)/2 + lo
	always_comb begin
		a_ok     = {1'b0, in_data.node_a} < nodes_in_use_q;
		b_ok     = {1'b0, in_data.node_b} < nodes_in_use_q;
		hi       = (in_data.node_a > in_data.node_b) ? in_data.node_a : in_data.node_b;
		lo       = (in_data.node_a > in_data.node_b) ? in_data.node_b : in_data.node_a;
		hi_p1    = {1'b0, hi} + (NODE_W+1)'(1);
		tri_prod = (IX_W+1)'(hi) * (IX_W+1)'(hi_p1);

		push_item.ok    = a_ok && b_ok && (in_data.node_a != in_data.node_b);
		push_item.a     = in_data.node_a;
		push_item.b     = in_data.node_b;
		push_item.ix    = tri_prod[IX_W:1] + IX_W'(lo);
		push_item.cost  = in_data.edge_cost_value;
		push_item.delta = in_data.edge_delta_value;
		// reserved constraint code counts as free
		push_item.con   = (in_data.constraint_code == CON_RSVD) ? CON_FREE
		                                                        : in_data.constraint_code;
		// unknown codes behave as the adjacency query
		push_item.kind  = (in_data.kind inside {[K_INSERT:K_ADJ]}) ? in_data.kind : K_ADJ;
	end

endmodule
`default_nettype wire

// ===== design/gep_queue.sv =====
// ----------------------------------------------------------------------------
// gep_queue: short operation queue between front and back
// Two-entry register FIFO; lets the front take items while the back works.
// ----------------------------------------------------------------------------
`default_nettype none
module gep_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire gep_pkg::q_item_t      push_item,
	input  wire logic                  pop,
	output gep_pkg::q_item_t           head,
	output gep_pkg::q_stat_t           stat
);
	import gep_pkg::*;

	q_item_t              slot_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	assign head       = slot_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == Q_CNT_W'(QUEUE_DEPTH));

endmodule
`default_nettype wire

// ===== design/gep_back.sv =====
// ----------------------------------------------------------------------------
// gep_back: edge and counter update engine
// Clears the store after reset, then runs each queued operation as a
// read-modify-write of one edge entry and the counters of both endpoints.
// ----------------------------------------------------------------------------
`default_nettype none
module gep_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gep_pkg::q_stat_t      q_stat,
	input  wire gep_pkg::q_item_t      q_head,
	output logic                       q_pop,
	output logic                       init_done,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output gep_pkg::out_t              out_data
);
	import gep_pkg::*;

	typedef struct packed {
		logic                      present;
		logic [1:0]                con;
		logic signed [VALUE_W-1:0] delta;
		logic signed [VALUE_W-1:0] cost;
	} edge_t;

	typedef struct packed {
		logic [DEG_W-1:0] deg;
		logic [DEG_W-1:0] forced;
		logic [DEG_W-1:0] forbid;
	} cnt_t;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_CALC  = 2'd2;
	localparam logic [1:0] ST_WRB   = 2'd3;

	// storage
	edge_t edge_mem [EDGE_SLOTS];
	cnt_t  cnt_mem  [MAX_NODES];

	logic [1:0]       state_q;
	logic [IX_W-1:0]  clr_idx_q;
	q_item_t          op_q;
	edge_t            edge_rd_q;
	cnt_t             cnt_a_q, cnt_b_q, cnt_b_new_q;
	out_t             res_q, out_data_q;
	logic             out_valid_q;
	logic signed [SUM_W-1:0] sum_q;

	// write ports
	logic              edge_we, cnt_we;
	logic [IX_W-1:0]   edge_wa;
	logic [NODE_W-1:0] cnt_wa;
	edge_t             edge_wd;
	cnt_t              cnt_wd;

	// update results
	logic [1:0]              status;
	logic                    act;
	edge_t                   edge_new;
	logic                    deg_up, deg_dn;
	logic [1:0]              con_dec, con_inc;
	logic signed [SUM_W-1:0] sum_new;
	logic signed [VALUE_W-1:0] rv;
	logic [1:0]              rc;
	cnt_t                    cnt_a_new, cnt_b_new;
	out_t                    res;
	logic                    out_load;

	function automatic cnt_t cnt_step(cnt_t c, logic up, logic dn,
		logic [1:0] dec, logic [1:0] inc);
		cnt_t r;
		r.deg    = c.deg + DEG_W'(up) - DEG_W'(dn);
		r.forced = c.forced + DEG_W'(inc == CON_FORCED) - DEG_W'(dec == CON_FORCED);
		r.forbid = c.forbid + DEG_W'(inc == CON_FORBIDDEN) - DEG_W'(dec == CON_FORBIDDEN);
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] sext(logic signed [VALUE_W-1:0] v);
		return {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
	endfunction

	assign init_done = (state_q != ST_CLEAR);
	assign q_pop     = (state_q == ST_IDLE) && !q_stat.empty;
	assign out_load  = (state_q == ST_WRB) && (!out_valid_q || out_ready);

	// operation decode and update of the fetched entry
	always_comb begin
		edge_new = edge_rd_q;
		deg_up   = 1'b0;
		deg_dn   = 1'b0;
		con_dec  = CON_FREE;
		con_inc  = CON_FREE;
		sum_new  = sum_q;
		rv       = '0;
		rc       = CON_FREE;

		if (!op_q.ok) begin
			status = STAT_BAD_NODE;
		end else if (op_q.kind == K_INSERT) begin
			status = edge_rd_q.present ? STAT_DUP : STAT_OK;
		end else if (op_q.kind == K_ADJ) begin
			status = STAT_OK;
		end else begin
			status = edge_rd_q.present ? STAT_OK : STAT_ABSENT;
		end
		act = (status == STAT_OK);

		if (act) begin
			case (op_q.kind)
				K_INSERT: begin
					edge_new.present = 1'b1;
					edge_new.cost    = op_q.cost;
					edge_new.delta   = '0;
					edge_new.con     = op_q.con;
					deg_up           = 1'b1;
					con_inc          = op_q.con;
					sum_new          = sum_q + sext(op_q.cost);
				end
				K_REMOVE: begin
					edge_new = '0;
					deg_dn   = 1'b1;
					con_dec  = edge_rd_q.con;
					sum_new  = sum_q - sext(edge_rd_q.cost);
				end
				K_SET_COST: begin
					edge_new.cost = op_q.cost;
					sum_new       = sum_q - sext(edge_rd_q.cost) + sext(op_q.cost);
				end
				K_GET_COST: begin
					rv = edge_rd_q.cost;
				end
				K_SET_CON: begin
					edge_new.con = op_q.con;
					con_dec      = edge_rd_q.con;
					con_inc      = op_q.con;
				end
				K_GET_CON: begin
					rc = edge_rd_q.con;
				end
				K_SET_DEL: begin
					edge_new.delta = op_q.delta;
				end
				K_GET_DEL: begin
					rv = edge_rd_q.delta;
				end
				default: begin
					rv = '0;
				end
			endcase
		end

		cnt_a_new = cnt_step(cnt_a_q, deg_up, deg_dn, con_dec, con_inc);
		cnt_b_new = cnt_step(cnt_b_q, deg_up, deg_dn, con_dec, con_inc);

		// result item; a rejected node pair reports its status, zeros and the cost total
		res.status          = status;
		res.adjacent        = op_q.ok ? edge_new.present : 1'b0;
		res.read_value      = rv;
		res.read_constraint = rc;
		res.degree_a        = op_q.ok ? cnt_a_new.deg : '0;
		res.forced_degree_a = op_q.ok ? cnt_a_new.forced : '0;
		res.forbidden_degree_a = op_q.ok ? cnt_a_new.forbid : '0;
		res.degree_b        = op_q.ok ? cnt_b_new.deg : '0;
		res.forced_degree_b = op_q.ok ? cnt_b_new.forced : '0;
		res.forbidden_degree_b = op_q.ok ? cnt_b_new.forbid : '0;
		res.total_cost      = sum_new;
	end

	// write port selection: clearing pass, edge + node a, then node b
	always_comb begin
		edge_we = 1'b0;
		edge_wa = op_q.ix;
		edge_wd = edge_new;
		cnt_we  = 1'b0;
		cnt_wa  = op_q.a;
		cnt_wd  = cnt_a_new;
		case (state_q)
			ST_CLEAR: begin
				edge_we = 1'b1;
				edge_wa = clr_idx_q;
				edge_wd = '0;
				cnt_we  = (clr_idx_q < IX_W'(MAX_NODES));
				cnt_wa  = clr_idx_q[NODE_W-1:0];
				cnt_wd  = '0;
			end
			ST_CALC: begin
				edge_we = 1'b1;
				cnt_we  = 1'b1;
			end
			ST_WRB: begin
				cnt_we = 1'b1;
				cnt_wa = op_q.b;
				cnt_wd = cnt_b_new_q;
			end
			default: begin
				edge_we = 1'b0;
			end
		endcase
	end

	// edge memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_wa] <= edge_wd;
		end
		if (q_pop) begin
			edge_rd_q <= edge_mem[q_head.ix];
		end
	end

	// counter memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (q_pop) begin
			cnt_a_q <= cnt_mem[q_head.a];
			cnt_b_q <= cnt_mem[q_head.b];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_head;
		end
		if (state_q == ST_CALC) begin
			cnt_b_new_q <= cnt_b_new;
			res_q       <= res;
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	// sequencer, cost total and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IX_W'(1);
					if (clr_idx_q == IX_W'(EDGE_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					sum_q   <= sum_new;
					state_q <= ST_WRB;
				end
				ST_WRB: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !q_pop)
		else $error("operation taken during clearing pass");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_calc_to_wrb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC |=> state_q == ST_WRB)
		else $error("update cycle not followed by node b write");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.status == STAT_BAD_NODE |->
			!out_data_q.adjacent && out_data_q.degree_a == '0 && out_data_q.degree_b == '0)
		else $error("rejected node pair reports state");

	a_dup_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.status == STAT_DUP |-> out_data_q.adjacent)
		else $error("duplicate insert without present edge");

endmodule
`default_nettype wire

// ===== tb/sv/graph_edge_table_with_degree_counts_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_edge_table_with_degree_counts_test: self-checking bench for the edge table
// Sends operation transfers with random gaps and accepts results with random
// stalls. A behavioral copy of the edge table, its node counters and its cost
// total computes each result, and every result transfer is compared field by
// field. Several node-count settings are used, each written while the table
// is idle.
// ----------------------------------------------------------------------------
module graph_edge_table_with_degree_counts_test;
	import gep_pkg::*;

	localparam logic [3:0] K_UNKNOWN_LO = 4'd9;
	localparam logic [3:0] K_UNKNOWN_HI = 4'd15;
	localparam int         LIMIT_CYCLES = 400000;
	localparam int         N_PHASES     = 9;

	// DUT signals, all known from time zero
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_t        in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_t       out_data;
	logic       cfg_we    = 1'b0;
	logic [6:0] cfg_wdata = '0;

	// behavioral copy of the table
	bit               link_present [EDGE_SLOTS];
	bit [VALUE_W-1:0] link_cost    [EDGE_SLOTS];
	bit [VALUE_W-1:0] link_delta   [EDGE_SLOTS];
	bit [1:0]         link_con     [EDGE_SLOTS];
	bit [DEG_W-1:0]   deg_total    [MAX_NODES];
	bit [DEG_W-1:0]   deg_forced   [MAX_NODES];
	bit [DEG_W-1:0]   deg_forbid   [MAX_NODES];
	bit [SUM_W-1:0]   cost_total;
	bit [CFG_W-1:0]   nodes_live = NODES_RESET;

	in_t  ops_to_send[$];
	out_t op_results_due[$];

	int mismatches   = 0;
	int results_seen = 0;
	int cycles       = 0;
	int gap_left     = 0;
	int stall_left   = 0;
	bit send_burst   = 1'b0;
	bit take_burst   = 1'b0;

	graph_edge_table_with_degree_counts i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	function automatic bit [SUM_W-1:0] widen(input bit [VALUE_W-1:0] v);
		return {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
	endfunction

	// forced/forbidden counters of both endpoints follow the edge constraint
	task automatic count_con(input int a, input int b, input bit [1:0] con, input bit up);
		bit [DEG_W-1:0] step;
		step = up ? DEG_W'(1) : {DEG_W{1'b1}};
		if (con == CON_FORCED) begin
			deg_forced[a] = deg_forced[a] + step;
			deg_forced[b] = deg_forced[b] + step;
		end else if (con == CON_FORBIDDEN) begin
			deg_forbid[a] = deg_forbid[a] + step;
			deg_forbid[b] = deg_forbid[b] + step;
		end
	endtask

	// apply one operation to the table copy and build its result
	task automatic apply_edge_op(input in_t op, output out_t res);
		int       a, b, hi, lo, ix;
		bit [1:0] con_in;
		res = '0;
		con_in = (op.constraint_code == CON_RSVD) ? CON_FREE : op.constraint_code;
		if ({1'b0, op.node_a} >= nodes_live || {1'b0, op.node_b} >= nodes_live
				|| op.node_a == op.node_b) begin
			res.status     = STAT_BAD_NODE;
			res.total_cost = cost_total;
			return;
		end
		a  = int'(op.node_a);
		b  = int'(op.node_b);
		hi = (a > b) ? a : b;
		lo = (a > b) ? b : a;
		ix = hi * (hi + 1) / 2 + lo;
		res.status = STAT_OK;
		if (op.kind == K_INSERT) begin
			if (link_present[ix]) begin
				res.status = STAT_DUP;
			end else begin
				link_present[ix] = 1'b1;
				link_cost[ix]    = op.edge_cost_value;
				link_delta[ix]   = '0;
				link_con[ix]     = con_in;
				deg_total[a]     = deg_total[a] + DEG_W'(1);
				deg_total[b]     = deg_total[b] + DEG_W'(1);
				count_con(a, b, con_in, 1'b1);
				cost_total = cost_total + widen(op.edge_cost_value);
			end
		end else if (op.kind <= K_GET_DEL) begin
			if (!link_present[ix]) begin
				res.status = STAT_ABSENT;
			end else begin
				case (op.kind)
					K_REMOVE: begin
						count_con(a, b, link_con[ix], 1'b0);
						deg_total[a]     = deg_total[a] - DEG_W'(1);
						deg_total[b]     = deg_total[b] - DEG_W'(1);
						cost_total       = cost_total - widen(link_cost[ix]);
						link_present[ix] = 1'b0;
						link_cost[ix]    = '0;
						link_delta[ix]   = '0;
						link_con[ix]     = CON_FREE;
					end
					K_SET_COST: begin
						cost_total    = cost_total - widen(link_cost[ix])
							+ widen(op.edge_cost_value);
						link_cost[ix] = op.edge_cost_value;
					end
					K_GET_COST: res.read_value = link_cost[ix];
					K_SET_CON: begin
						count_con(a, b, link_con[ix], 1'b0);
						link_con[ix] = con_in;
						count_con(a, b, con_in, 1'b1);
					end
					K_GET_CON: res.read_constraint = link_con[ix];
					K_SET_DEL: link_delta[ix] = op.edge_delta_value;
					default:   res.read_value = link_delta[ix];
				endcase
			end
		end
		res.adjacent           = link_present[ix];
		res.degree_a           = deg_total[a];
		res.forced_degree_a    = deg_forced[a];
		res.forbidden_degree_a = deg_forbid[a];
		res.degree_b           = deg_total[b];
		res.forced_degree_b    = deg_forced[b];
		res.forbidden_degree_b = deg_forbid[b];
		res.total_cost         = cost_total;
	endtask

	task automatic check_field(input string name, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %h got %h", results_seen, name, want, got);
		end
	endtask

	// operation transfer: drive from the send queue, predict on each transfer
	always @(posedge clk) begin
		out_t res;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				apply_edge_op(in_data, res);
				op_results_due.push_back(res);
				gap_left = send_burst ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 39) == 0)
					send_burst = !send_burst;
			end
			if (in_valid && !in_ready) begin
				// hold the pending transfer
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (ops_to_send.size() > 0) begin
				in_data  <= ops_to_send.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result transfer: random stalls, compare against the oldest prediction
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (op_results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: unexpected, got %h", results_seen, out_data);
				end else begin
					want = op_results_due.pop_front();
					check_field("status", SUM_W'(want.status), SUM_W'(out_data.status));
					check_field("adjacent", SUM_W'(want.adjacent),
						SUM_W'(out_data.adjacent));
					check_field("read_value", SUM_W'(want.read_value),
						SUM_W'(out_data.read_value));
					check_field("read_constraint", SUM_W'(want.read_constraint),
						SUM_W'(out_data.read_constraint));
					check_field("degree_a", SUM_W'(want.degree_a),
						SUM_W'(out_data.degree_a));
					check_field("forced_degree_a", SUM_W'(want.forced_degree_a),
						SUM_W'(out_data.forced_degree_a));
					check_field("forbidden_degree_a", SUM_W'(want.forbidden_degree_a),
						SUM_W'(out_data.forbidden_degree_a));
					check_field("degree_b", SUM_W'(want.degree_b),
						SUM_W'(out_data.degree_b));
					check_field("forced_degree_b", SUM_W'(want.forced_degree_b),
						SUM_W'(out_data.forced_degree_b));
					check_field("forbidden_degree_b", SUM_W'(want.forbidden_degree_b),
						SUM_W'(out_data.forbidden_degree_b));
					check_field("total_cost", want.total_cost, out_data.total_cost);
				end
				stall_left = take_burst ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 39) == 0)
					take_burst = !take_burst;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic queue_op(input logic [3:0] kind, input int a, input int b,
			input logic [31:0] cost, input logic [31:0] delta, input logic [1:0] con);
		in_t op;
		op.kind             = kind;
		op.node_a           = NODE_W'(a);
		op.node_b           = NODE_W'(b);
		op.edge_cost_value  = cost;
		op.edge_delta_value = delta;
		op.constraint_code  = con;
		ops_to_send.push_back(op);
	endtask

	// Q16.16 value, extremes now and then
	function automatic logic [31:0] rand_q16();
		if ($urandom_range(0, 9) != 0)
			return $urandom;
		case ($urandom_range(0, 3))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	// mostly nodes from a small pool so edges get hit again
	function automatic int pick_node(input int span);
		if ($urandom_range(0, 3) != 0)
			return $urandom_range(0, span - 1);
		return $urandom_range(0, 63);
	endfunction

	function automatic in_t rand_op(input int span);
		in_t op;
		int  r;
		r = $urandom_range(0, 99);
		if (r < 24)      op.kind = K_INSERT;
		else if (r < 36) op.kind = K_REMOVE;
		else if (r < 44) op.kind = K_SET_COST;
		else if (r < 52) op.kind = K_GET_COST;
		else if (r < 62) op.kind = K_SET_CON;
		else if (r < 70) op.kind = K_GET_CON;
		else if (r < 78) op.kind = K_SET_DEL;
		else if (r < 86) op.kind = K_GET_DEL;
		else if (r < 94) op.kind = K_ADJ;
		else             op.kind = 4'($urandom_range(K_UNKNOWN_LO, K_UNKNOWN_HI));
		op.node_a = NODE_W'(pick_node(span));
		op.node_b = ($urandom_range(0, 15) == 0) ? op.node_a : NODE_W'(pick_node(span));
		op.edge_cost_value  = rand_q16();
		op.edge_delta_value = rand_q16();
		op.constraint_code  = 2'($urandom_range(0, 3));
		return op;
	endfunction

	// wait until everything sent has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (ops_to_send.size() != 0 || in_valid || op_results_due.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	// main sequence
	initial begin
		int phase_cfg   [N_PHASES];
		int phase_span  [N_PHASES];
		int phase_items [N_PHASES];
		int p, k;

		phase_cfg   = '{2, 0, 127, 8, 1, 64, 5, 0, 63};
		phase_span  = '{4, 4, 6, 10, 3, 12, 7, 16, 64};
		phase_items = '{60, 40, 300, 250, 40, 300, 250, 200, 160};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part under the reset node count
		queue_op(K_INSERT,   0, 63, 32'h7fff_ffff, $urandom, CON_FORCED);
		queue_op(K_INSERT,  63,  0, $urandom, $urandom, CON_FREE);      // duplicate
		queue_op(K_GET_COST, 63, 0, $urandom, $urandom, CON_FREE);
		queue_op(K_INSERT,   1,  2, 32'h8000_0000, $urandom, CON_FORBIDDEN);
		queue_op(K_INSERT,   3,  2, 32'hffff_ffff, $urandom, CON_RSVD);  // stored as free
		queue_op(K_GET_CON,  2,  3, $urandom, $urandom, CON_FORCED);
		queue_op(K_GET_DEL,  2,  3, $urandom, $urandom, CON_FREE);      // insert clears delta
		queue_op(K_SET_CON,  1,  2, $urandom, $urandom, CON_FORCED);
		queue_op(K_GET_CON,  2,  1, $urandom, $urandom, CON_FREE);
		queue_op(K_SET_COST, 0, 63, 32'h8000_0000, $urandom, CON_FREE);
		queue_op(K_SET_DEL,  1,  2, $urandom, 32'h7fff_ffff, CON_FREE);
		queue_op(K_GET_DEL,  1,  2, $urandom, $urandom, CON_FREE);
		queue_op(K_ADJ,      0, 63, $urandom, $urandom, CON_FREE);
		queue_op(K_ADJ,      5,  6, $urandom, $urandom, CON_FREE);      // absent, still ok
		queue_op(K_UNKNOWN_LO, 1, 2, $urandom, $urandom, CON_FREE);
		queue_op(K_UNKNOWN_HI, 4, 4, $urandom, $urandom, CON_FREE);     // equal nodes
		queue_op(K_INSERT,   5,  5, $urandom, $urandom, CON_FORCED);    // equal nodes
		queue_op(K_REMOVE,  63,  0, $urandom, $urandom, CON_FREE);
		queue_op(K_REMOVE,   0, 63, $urandom, $urandom, CON_FREE);      // now absent
		queue_op(K_GET_COST, 0, 63, $urandom, $urandom, CON_FREE);
		queue_op(K_SET_COST, 0, 63, 32'h8000_0000, $urandom, CON_FREE);
		queue_op(K_SET_CON, 63,  0, $urandom, $urandom, CON_FORBIDDEN);
		queue_op(K_SET_DEL,  0, 63, $urandom, 32'h8000_0000, CON_FREE);
		queue_op(K_GET_CON,  0, 63, $urandom, $urandom, CON_FREE);
		queue_op(K_REMOVE,   2,  1, $urandom, $urandom, CON_FREE);      // forced edge
		wait_drained();

		// random phases, one node-count setting each
		for (p = 0; p < N_PHASES; p++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= (p == 7) ? 7'($urandom_range(0, 127)) : 7'(phase_cfg[p]);
			nodes_live = (p == 7) ? 7'($urandom_range(0, 127)) : 7'(phase_cfg[p]);
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			if (cfg_wdata != nodes_live)
				nodes_live = cfg_wdata;
			// hub: one node gets every possible edge
			if (phase_cfg[p] == 64) begin
				for (k = 1; k < 64; k++)
					queue_op(K_INSERT, 0, k, rand_q16(), $urandom, 2'($urandom_range(0, 3)));
			end
			for (k = 0; k < phase_items[p]; k++)
				ops_to_send.push_back(rand_op(phase_span[p]));
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && op_results_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
